// ===== rtl/assert_macros.svh =====
// assertion helpers used by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/srlp_pkg.sv =====
`timescale 1ns / 1ps

package srlp_pkg;

  localparam int unsigned PosW = 8;

  // record kinds on the output
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_TEMP    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // characters of interest
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // per-line outcome tracking
  typedef enum logic [7:0] {
    V_PEND    = 8'b0000_0001,
    V_STAR1   = 8'b0000_0010,
    V_STAR2   = 8'b0000_0100,
    V_START   = 8'b0000_1000,
    V_INVALID = 8'b0001_0000,
    V_SILENT  = 8'b0010_0000,
    V_ERROR   = 8'b0100_0000,
    V_TEMP    = 8'b1000_0000
  } verdict_e;

  // hex digit value, bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/sensor_record_line_parser_core.sv =====
// Sensor record line parser: takes one received byte per request and returns at
// most one record per line. 'S' or 'T' opens a line, CR/LF or reaching
// LINE_LIMIT characters closes it. Every byte is handled by the field
// accumulators and the per-line verdict register, so one request is accepted
// each clock unless the full output register is stalled; the result lands in
// an output register the cycle after the closing byte, and a new byte is taken while the output is drained.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sensor_record_line_parser_core #(
  parameter int unsigned LINE_LIMIT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  record_kind_o,
  output logic [7:0]  sensor_id_o,
  output logic [11:0] current_temp_o,
  output logic [11:0] lowest_temp_o,
  output logic [11:0] highest_temp_o,
  output logic [3:0]  error_code_o
);

  localparam logic [srlp_pkg::PosW-1:0] Limit = srlp_pkg::PosW'(LINE_LIMIT);

  logic                       accepting_q, accepting_d;
  logic [srlp_pkg::PosW-1:0]  pos_q, pos_d;
  logic                       is_temp_q, is_temp_d;
  logic [7:0]                 id_q, id_d;
  logic [11:0]                cur_q, cur_d;
  logic [11:0]                low_q, low_d;
  logic [11:0]                high_q, high_d;
  logic [3:0]                 err_q, err_d;
  srlp_pkg::verdict_e         verdict_q, verdict_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  oid_q, oid_d;
  logic [11:0] ocur_q, ocur_d;
  logic [11:0] olow_q, olow_d;
  logic [11:0] ohigh_q, ohigh_d;
  logic [3:0]  oerr_q, oerr_d;

  logic                      accept;
  logic                      emit;
  logic [4:0]                dig;
  logic                      is_hex;
  logic                      fin;
  logic [srlp_pkg::PosW-1:0] fin_pos;
  srlp_pkg::verdict_e        fin_v;
  logic                      decided;

  // handshake: the output register frees up when it is empty or being taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign dig        = srlp_pkg::hex_value(rx_byte_i);
  assign is_hex     = !dig[4];

  assign decided = verdict_q inside {srlp_pkg::V_START, srlp_pkg::V_INVALID,
                                     srlp_pkg::V_SILENT, srlp_pkg::V_ERROR,
                                     srlp_pkg::V_TEMP};

  // per-byte line state update
  always_comb begin
    accepting_d = accepting_q;
    pos_d       = pos_q;
    is_temp_d   = is_temp_q;
    id_d        = id_q;
    cur_d       = cur_q;
    low_d       = low_q;
    high_d      = high_q;
    err_d       = err_q;
    verdict_d   = verdict_q;
    fin         = 1'b0;
    fin_pos     = pos_q;
    if (rx_byte_i inside {srlp_pkg::CHAR_S, srlp_pkg::CHAR_T}) begin
      // new line, whatever was in progress is dropped
      accepting_d = 1'b1;
      pos_d       = srlp_pkg::PosW'(1);
      is_temp_d   = (rx_byte_i == srlp_pkg::CHAR_T);
      id_d        = '0;
      cur_d       = '0;
      low_d       = '0;
      high_d      = '0;
      err_d       = '0;
      verdict_d   = srlp_pkg::V_PEND;
    end else if (rx_byte_i inside {srlp_pkg::CHAR_CR, srlp_pkg::CHAR_LF}) begin
      if (accepting_q) begin
        accepting_d = 1'b0;
        fin         = 1'b1;
      end
    end else if (accepting_q) begin
      // field decode by position
      if (!decided) begin
        if (pos_q inside {8'd1, 8'd2}) begin
          if (!is_hex) begin
            verdict_d = srlp_pkg::V_INVALID;
          end else begin
            id_d = {id_q[3:0], dig[3:0]};
            if (pos_q == 8'd2 && !is_temp_q) verdict_d = srlp_pkg::V_START;
          end
        end else if (pos_q inside {8'd3, 8'd7, 8'd11}) begin
          if (rx_byte_i != srlp_pkg::CHAR_SPACE) begin
            verdict_d = (pos_q == 8'd3) ? srlp_pkg::V_SILENT : srlp_pkg::V_INVALID;
          end
        end else if (pos_q == 8'd4) begin
          if (is_hex) cur_d = {cur_q[7:0], dig[3:0]};
          else if (rx_byte_i == srlp_pkg::CHAR_STAR) verdict_d = srlp_pkg::V_STAR1;
          else verdict_d = srlp_pkg::V_INVALID;
        end else if (pos_q == 8'd5) begin
          if (verdict_q == srlp_pkg::V_STAR1) begin
            verdict_d = (rx_byte_i == srlp_pkg::CHAR_STAR) ? srlp_pkg::V_STAR2
                                                           : srlp_pkg::V_INVALID;
          end else if (is_hex) begin
            cur_d = {cur_q[7:0], dig[3:0]};
          end else begin
            verdict_d = srlp_pkg::V_INVALID;
          end
        end else if (pos_q == 8'd6) begin
          if (!is_hex) begin
            verdict_d = srlp_pkg::V_INVALID;
          end else if (verdict_q == srlp_pkg::V_STAR2) begin
            err_d     = dig[3:0];
            verdict_d = srlp_pkg::V_ERROR;
          end else begin
            cur_d = {cur_q[7:0], dig[3:0]};
          end
        end else if (pos_q inside {[8'd8:8'd10]}) begin
          if (!is_hex) verdict_d = srlp_pkg::V_INVALID;
          else low_d = {low_q[7:0], dig[3:0]};
        end else if (pos_q inside {[8'd12:8'd14]}) begin
          if (!is_hex) begin
            verdict_d = srlp_pkg::V_INVALID;
          end else begin
            high_d = {high_q[7:0], dig[3:0]};
            if (pos_q == 8'd14) verdict_d = srlp_pkg::V_TEMP;
          end
        end
      end
      pos_d   = pos_q + 8'd1;
      fin_pos = pos_d;
      // line limit reached
      if (pos_d >= Limit) begin
        accepting_d = 1'b0;
        fin         = 1'b1;
      end
    end
  end

  // closing a line: settle an open verdict and build the record
  always_comb begin
    fin_v   = verdict_d;
    emit    = 1'b0;
    kind_d  = srlp_pkg::KIND_INVALID;
    oid_d   = '0;
    ocur_d  = '0;
    olow_d  = '0;
    ohigh_d = '0;
    oerr_d  = '0;
    if (verdict_d inside {srlp_pkg::V_PEND, srlp_pkg::V_STAR1, srlp_pkg::V_STAR2}) begin
      if (verdict_d == srlp_pkg::V_PEND && is_temp_d && fin_pos == 8'd3) begin
        fin_v = srlp_pkg::V_SILENT;
      end else begin
        fin_v = srlp_pkg::V_INVALID;
      end
    end
    if (fin) begin
      case (fin_v)
        srlp_pkg::V_SILENT: begin
          emit = 1'b0;
        end
        srlp_pkg::V_START: begin
          emit   = 1'b1;
          kind_d = srlp_pkg::KIND_START;
          oid_d  = id_d;
        end
        srlp_pkg::V_TEMP: begin
          emit    = 1'b1;
          kind_d  = srlp_pkg::KIND_TEMP;
          oid_d   = id_d;
          ocur_d  = cur_d;
          olow_d  = low_d;
          ohigh_d = high_d;
        end
        srlp_pkg::V_ERROR: begin
          emit   = 1'b1;
          kind_d = srlp_pkg::KIND_ERROR;
          oid_d  = id_d;
          oerr_d = err_d;
        end
        default: begin
          emit   = 1'b1;
          kind_d = srlp_pkg::KIND_INVALID;
        end
      endcase
    end
  end

  // output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepting_q <= 1'b0;
      pos_q       <= '0;
      is_temp_q   <= 1'b0;
      id_q        <= '0;
      cur_q       <= '0;
      low_q       <= '0;
      high_q      <= '0;
      err_q       <= '0;
      verdict_q   <= srlp_pkg::V_PEND;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        accepting_q <= accepting_d;
        pos_q       <= pos_d;
        is_temp_q   <= is_temp_d;
        id_q        <= id_d;
        cur_q       <= cur_d;
        low_q       <= low_d;
        high_q      <= high_d;
        err_q       <= err_d;
        verdict_q   <= verdict_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q  <= kind_d;
      oid_q   <= oid_d;
      ocur_q  <= ocur_d;
      olow_q  <= olow_d;
      ohigh_q <= ohigh_d;
      oerr_q  <= oerr_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_kind_o  = kind_q;
  assign sensor_id_o    = oid_q;
  assign current_temp_o = ocur_q;
  assign lowest_temp_o  = olow_q;
  assign highest_temp_o = ohigh_q;
  assign error_code_o   = oerr_q;

  // checks
  `ASSERT_ALWAYS(a_pos_in_range, !accepting_q || (pos_q != '0 && pos_q < Limit),
                 "line position out of range")
  `ASSERT_NEXT(a_eol_closes, accept && (rx_byte_i == srlp_pkg::CHAR_CR ||
               rx_byte_i == srlp_pkg::CHAR_LF), !accepting_q, "line still open after end")
  `ASSERT_NEXT(a_emit_shows, accept && emit, out_valid_o, "record not presented")
  `ASSERT_ALWAYS(a_start_clean, !(out_valid_o && record_kind_o == srlp_pkg::KIND_START) ||
                 (current_temp_o == '0 && error_code_o == '0), "start record carries data")

endmodule
